/* rtl/amqp_fd_pkg.sv */
// Shared types and constants for the AMQP frame deframer with method check.
package amqp_fd_pkg;

   localparam int BYTE_W   = 8;
   localparam int CHAN_W   = 16;
   localparam int SIZE_W   = 32;
   localparam int ID_W     = 16;
   localparam int STATUS_W = 3;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 4;

   localparam logic [BYTE_W-1:0] END_MARK = 8'hCE;

   localparam logic [ADDR_W-1:0] ADDR_CLASS  = 4'h0;
   localparam logic [ADDR_W-1:0] ADDR_METHOD = 4'h4;
   localparam logic [ADDR_W-1:0] ADDR_CHECK  = 4'h8;

   localparam logic [1:0] REG_CLASS  = 2'd0;
   localparam logic [1:0] REG_METHOD = 2'd1;
   localparam logic [1:0] REG_CHECK  = 2'd2;

   localparam logic [ID_W-1:0] CLASS_RESET  = 16'd10;
   localparam logic [ID_W-1:0] METHOD_RESET = 16'd10;

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_CHAN,
      PH_SIZE,
      PH_LOAD,
      PH_END
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_BAD_END,
      ST_MISMATCH,
      ST_TRUNC,
      ST_SHORT
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0] expected_class;
      logic [ID_W-1:0] expected_method;
      logic            check_method;
   } cfg_type;

endpackage

/* rtl/amqp_fd_if.sv */
// Channel interfaces: input byte channel and result channel.
interface amqp_fd_req_if;
   import amqp_fd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              buffer_last;

   modport source (output valid, output in_byte, output buffer_last, input ready);
   modport sink   (input valid, input in_byte, input buffer_last, output ready);
endinterface

interface amqp_fd_rsp_if;
   import amqp_fd_pkg::*;
   logic                valid;
   logic                ready;
   logic                arg_valid;
   logic [BYTE_W-1:0]   arg_byte;
   logic                frame_done;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   frame_type;
   logic [CHAN_W-1:0]   channel_number;
   logic [SIZE_W-1:0]   payload_size;

   modport source (output valid, output arg_valid, output arg_byte, output frame_done,
                   output status, output frame_type, output channel_number,
                   output payload_size, input ready);
   modport sink   (input valid, input arg_valid, input arg_byte, input frame_done,
                   input status, input frame_type, input channel_number,
                   input payload_size, output ready);
endinterface

/* rtl/amqp_fd_csr.sv */
// APB-style configuration registers for the deframer.
module amqp_fd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [amqp_fd_pkg::ADDR_W-1:0]    paddr,
   input  logic [amqp_fd_pkg::DATA_W-1:0]    pwdata,
   output logic [amqp_fd_pkg::DATA_W-1:0]    prdata,
   output logic                              pready,
   output amqp_fd_pkg::cfg_type              cfg
);
   import amqp_fd_pkg::*;

   logic [ID_W-1:0] class_ff, class_in;
   logic [ID_W-1:0] method_ff, method_in;
   logic            check_ff, check_in;
   logic            wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      class_in  = class_ff;
      method_in = method_ff;
      check_in  = check_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_CLASS:  class_in  = pwdata[ID_W-1:0];
            REG_METHOD: method_in = pwdata[ID_W-1:0];
            REG_CHECK:  check_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff  <= CLASS_RESET;
         method_ff <= METHOD_RESET;
         check_ff  <= 1'b1;
      end else begin
         class_ff  <= class_in;
         method_ff <= method_in;
         check_ff  <= check_in;
      end
   end

   always_comb begin
      case (paddr)
         ADDR_CLASS:  prdata = {{(DATA_W-ID_W){1'b0}}, class_ff};
         ADDR_METHOD: prdata = {{(DATA_W-ID_W){1'b0}}, method_ff};
         ADDR_CHECK:  prdata = {{(DATA_W-1){1'b0}}, check_ff};
         default:     prdata = '0;
      endcase
   end

   assign cfg.expected_class  = class_ff;
   assign cfg.expected_method = method_ff;
   assign cfg.check_method    = check_ff;

endmodule

/* rtl/amqp_fd_core.sv */
// Frame parser: phase state, header registers and the result register.
module amqp_fd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  amqp_fd_pkg::cfg_type cfg,
   amqp_fd_req_if.sink          req,
   amqp_fd_rsp_if.source        rsp
);
   import amqp_fd_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [SIZE_W-1:0] cnt_ff, cnt_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [31:0]       hdr_ff, hdr_in;
   status_type        err_ff, err_in;

   logic                out_valid_ff;
   logic                arg_valid_ff;
   logic [BYTE_W-1:0]   arg_byte_ff;
   logic                done_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [BYTE_W-1:0]   ftype_ff;
   logic [CHAN_W-1:0]   fchan_ff;
   logic [SIZE_W-1:0]   fsize_ff;

   logic       accept;
   logic       arg;
   logic       done;
   status_type st;
   logic       emit;

   assign req.ready = !out_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign emit      = arg || done;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      type_in  = type_ff;
      chan_in  = chan_ff;
      size_in  = size_ff;
      hdr_in   = hdr_ff;
      err_in   = err_ff;
      arg      = 1'b0;
      done     = 1'b0;
      st       = ST_OK;
      case (phase_ff)
         PH_TYPE: begin
            type_in  = req.in_byte;
            chan_in  = '0;
            size_in  = '0;
            hdr_in   = '0;
            err_in   = ST_OK;
            cnt_in   = '0;
            phase_in = PH_CHAN;
         end
         PH_CHAN: begin
            chan_in = {chan_ff[CHAN_W-BYTE_W-1:0], req.in_byte};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 32'd1) begin
               cnt_in   = '0;
               phase_in = PH_SIZE;
            end
         end
         PH_SIZE: begin
            size_in = {size_ff[SIZE_W-BYTE_W-1:0], req.in_byte};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 32'd3) begin
               cnt_in = '0;
               if (size_in == '0) begin
                  if (cfg.check_method && err_ff == ST_OK)
                     err_in = ST_SHORT;
                  phase_in = PH_END;
               end else begin
                  phase_in = PH_LOAD;
               end
            end
         end
         PH_LOAD: begin
            if (!cfg.check_method) begin
               arg = 1'b1;
            end else if (cnt_ff < 32'd4) begin
               hdr_in = {hdr_ff[23:0], req.in_byte};
               if (cnt_ff == 32'd3 &&
                   (hdr_in[31:16] != cfg.expected_class ||
                    hdr_in[15:0] != cfg.expected_method))
                  err_in = ST_MISMATCH;
            end else if (err_ff == ST_OK) begin
               arg = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_in == size_ff) begin
               if (cfg.check_method && size_ff < 32'd4 && err_in == ST_OK)
                  err_in = ST_SHORT;
               phase_in = PH_END;
            end
         end
         PH_END: begin
            done     = 1'b1;
            st       = (req.in_byte != END_MARK) ? ST_BAD_END : err_ff;
            phase_in = PH_TYPE;
            cnt_in   = '0;
         end
         default: begin
            phase_in = PH_TYPE;
            cnt_in   = '0;
         end
      endcase
      if (req.buffer_last && !done) begin
         done     = 1'b1;
         st       = ST_TRUNC;
         phase_in = PH_TYPE;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         cnt_ff   <= '0;
         type_ff  <= '0;
         chan_ff  <= '0;
         size_ff  <= '0;
         hdr_ff   <= '0;
         err_ff   <= ST_OK;
      end else if (accept) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         type_ff  <= type_in;
         chan_ff  <= chan_in;
         size_ff  <= size_in;
         hdr_ff   <= hdr_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (accept)
         out_valid_ff <= emit;
      else if (rsp.ready)
         out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         arg_valid_ff <= arg;
         arg_byte_ff  <= arg ? req.in_byte : '0;
         done_ff      <= done;
         status_ff    <= st;
         ftype_ff     <= type_in;
         fchan_ff     <= chan_in;
         fsize_ff     <= size_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.arg_valid      = arg_valid_ff;
   assign rsp.arg_byte       = arg_byte_ff;
   assign rsp.frame_done     = done_ff;
   assign rsp.status         = status_ff;
   assign rsp.frame_type     = ftype_ff;
   assign rsp.channel_number = fchan_ff;
   assign rsp.payload_size   = fsize_ff;

`ifndef NO_ASSERTIONS
   a_status_needs_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !done_ff |-> status_ff == ST_OK)
      else $error("nonzero status without frame_done");

   a_idle_arg_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !arg_valid_ff |-> arg_byte_ff == '0)
      else $error("arg_byte nonzero without arg_valid");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      accept && req.buffer_last |=> phase_ff == PH_TYPE && out_valid_ff && done_ff)
      else $error("buffer_last did not close the frame");

   a_end_returns: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_END |=> phase_ff == PH_TYPE && done_ff)
      else $error("end byte did not close the frame");

   a_chan_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CHAN |-> cnt_ff < 32'd2)
      else $error("channel byte count out of range");
`endif

endmodule

/* rtl/amqp_frame_deframer_method_check.sv */
// AMQP frame deframer with method header check: one byte enters per clock
// whenever the result register is empty or being taken; each accepted byte
// is parsed combinationally and its result, if any, appears in the result
// register on the next edge. Sustained rate is one byte per cycle while the
// result register is empty or being taken. Frame status ok, bad end,
// mismatch, truncated or short payload closes each attempt; a bad status
// means the passed-out bytes must be discarded.
module amqp_frame_deframer_method_check (
   input  logic                           clock,
   input  logic                           reset,
   amqp_fd_req_if.sink                    req_chan,
   amqp_fd_rsp_if.source                  rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [amqp_fd_pkg::ADDR_W-1:0] paddr,
   input  logic [amqp_fd_pkg::DATA_W-1:0] pwdata,
   output logic [amqp_fd_pkg::DATA_W-1:0] prdata,
   output logic                           pready
);
   import amqp_fd_pkg::*;

   cfg_type cfg;

   amqp_fd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   amqp_fd_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule
